FILE: rtl/core/lpbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbp_pkg
// Shared types and constants for the LED PWM bit-plane packer.
// ----------------------------------------------------------------------------
package lpbp_pkg;

    localparam int CHAN_W = 8;
    localparam int ADDR_W = 7;
    localparam int WORD_W = 32;

    localparam logic [CHAN_W-1:0] PERIOD_RESET = 8'd7;

    typedef struct packed {
        logic [CHAN_W-1:0]   pixel_brightness;
        logic [3*CHAN_W-1:0] pixel_color;
    } pixel_t;

    typedef struct packed {
        logic [ADDR_W-1:0] word_address;
        logic [WORD_W-1:0] red_word;
        logic [WORD_W-1:0] green_word;
        logic [WORD_W-1:0] blue_word;
        logic              frame_done;
    } word_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic calc_duty;
        logic pack;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit;
        logic out_stall;
    } dp_status_t;

endpackage

FILE: rtl/core/lpbp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbp_ctrl
// Sequencer: accept a pixel, compute duties, then pack the bits.
// ----------------------------------------------------------------------------
module lpbp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lpbp_pkg::dp_status_t sts,
    output lpbp_pkg::ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DUTY = 2'd1;
    localparam logic [1:0] ST_PACK = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready       = (state_reg == ST_IDLE);
    assign cmd.load      = s_valid && s_ready;
    assign cmd.calc_duty = (state_reg == ST_DUTY);
    // hold in pack while a word is due and the output register is still full
    assign cmd.pack      = (state_reg == ST_PACK) && !(sts.emit && sts.out_stall);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DUTY;
                end
            end
            ST_DUTY: begin
                state_next = ST_PACK;
            end
            ST_PACK: begin
                if (cmd.pack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/lpbp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbp_datapath
// Level and duty multipliers, bit accumulators, position counters, output reg.
// ----------------------------------------------------------------------------
module lpbp_datapath #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 32,
    parameter int PANEL_WIDTH  = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lpbp_pkg::pixel_t                  s_data,
    input  logic                              cfg_we,
    input  logic [lpbp_pkg::CHAN_W-1:0]       cfg_wdata,
    input  lpbp_pkg::ctrl_cmd_t               cmd,
    output lpbp_pkg::dp_status_t              sts,
    output logic                              m_valid,
    input  logic                              m_ready,
    output lpbp_pkg::word_t                   m_data
);

    localparam int CW    = lpbp_pkg::CHAN_W;
    localparam int AW    = lpbp_pkg::ADDR_W;
    localparam int WW    = lpbp_pkg::WORD_W;
    localparam int COL_W = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
    localparam int ROW_W = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
    localparam int BIT_W = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;

    logic [CW-1:0]    period_reg;
    logic [CW-1:0]    phase_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [BIT_W-1:0] bit_reg;
    logic [AW-1:0]    base_reg;
    logic [WW-1:0]    red_acc_reg;
    logic [WW-1:0]    grn_acc_reg;
    logic [WW-1:0]    blu_acc_reg;
    logic [CW-1:0]    lvl_r_reg;
    logic [CW-1:0]    lvl_g_reg;
    logic [CW-1:0]    lvl_b_reg;
    logic [CW:0]      duty_r_reg;
    logic [CW:0]      duty_g_reg;
    logic [CW:0]      duty_b_reg;
    logic             out_valid_reg;
    lpbp_pkg::word_t  out_reg;

    logic [2*CW-1:0]  prod_r;
    logic [2*CW-1:0]  prod_g;
    logic [2*CW-1:0]  prod_b;
    logic [CW:0]      period_p1;
    logic [2*CW:0]    dprod_r;
    logic [2*CW:0]    dprod_g;
    logic [2*CW:0]    dprod_b;
    logic             row_end;
    logic             frame_end;
    logic             panel_end;
    logic [WW-1:0]    bit_mask;
    logic [WW-1:0]    red_new;
    logic [WW-1:0]    grn_new;
    logic [WW-1:0]    blu_new;
    logic [CW-1:0]    phase_inc;

    // level = brightness * channel >> 8
    assign prod_r = s_data.pixel_brightness * s_data.pixel_color[3*CW-1:2*CW];
    assign prod_g = s_data.pixel_brightness * s_data.pixel_color[2*CW-1:CW];
    assign prod_b = s_data.pixel_brightness * s_data.pixel_color[CW-1:0];

    // duty = level * (period + 1) >> 8
    assign period_p1 = (CW+1)'(period_reg) + (CW+1)'(1);
    assign dprod_r   = lvl_r_reg * period_p1;
    assign dprod_g   = lvl_g_reg * period_p1;
    assign dprod_b   = lvl_b_reg * period_p1;

    assign row_end   = (col_reg == COL_W'(FRAME_WIDTH - 1));
    assign frame_end = row_end && (row_reg == ROW_W'(FRAME_HEIGHT - 1));
    assign panel_end = (bit_reg == BIT_W'(PANEL_WIDTH - 1));

    // positions of 32 or more shift out to an empty mask
    assign bit_mask = WW'(1) << bit_reg;
    assign red_new  = red_acc_reg | (({1'b0, phase_reg} < duty_r_reg) ? bit_mask : '0);
    assign grn_new  = grn_acc_reg | (({1'b0, phase_reg} < duty_g_reg) ? bit_mask : '0);
    assign blu_new  = blu_acc_reg | (({1'b0, phase_reg} < duty_b_reg) ? bit_mask : '0);

    assign phase_inc = phase_reg + CW'(1);

    assign sts.emit      = panel_end || row_end;
    assign sts.out_stall = out_valid_reg && !m_ready;
    assign m_valid       = out_valid_reg;
    assign m_data        = out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lvl_r_reg <= prod_r[2*CW-1:CW];
            lvl_g_reg <= prod_g[2*CW-1:CW];
            lvl_b_reg <= prod_b[2*CW-1:CW];
        end
        if (cmd.calc_duty) begin
            duty_r_reg <= dprod_r[2*CW:CW];
            duty_g_reg <= dprod_g[2*CW:CW];
            duty_b_reg <= dprod_b[2*CW:CW];
        end
        if (cmd.pack && sts.emit) begin
            out_reg.word_address <= AW'(row_reg) + base_reg;
            out_reg.red_word     <= red_new;
            out_reg.green_word   <= grn_new;
            out_reg.blue_word    <= blu_new;
            out_reg.frame_done   <= frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= lpbp_pkg::PERIOD_RESET;
            phase_reg     <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            bit_reg       <= '0;
            base_reg      <= '0;
            red_acc_reg   <= '0;
            grn_acc_reg   <= '0;
            blu_acc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                period_reg <= cfg_wdata;
            end
            if (cmd.pack && sts.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.pack) begin
                if (sts.emit) begin
                    red_acc_reg <= '0;
                    grn_acc_reg <= '0;
                    blu_acc_reg <= '0;
                end else begin
                    red_acc_reg <= red_new;
                    grn_acc_reg <= grn_new;
                    blu_acc_reg <= blu_new;
                end
                if (row_end) begin
                    col_reg  <= '0;
                    bit_reg  <= '0;
                    base_reg <= '0;
                    if (frame_end) begin
                        row_reg <= '0;
                        if (phase_inc >= period_reg) begin
                            phase_reg <= '0;
                        end else begin
                            phase_reg <= phase_inc;
                        end
                    end else begin
                        row_reg <= row_reg + ROW_W'(1);
                    end
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                    if (panel_end) begin
                        bit_reg  <= '0;
                        base_reg <= base_reg + AW'(FRAME_HEIGHT);
                    end else begin
                        bit_reg <= bit_reg + BIT_W'(1);
                    end
                end
            end
        end
    end

endmodule

FILE: rtl/core/led_pwm_bitplane_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pwm_bitplane_packer
// Packs raster pixels into per-color PWM bit-plane words for an LED panel.
// ----------------------------------------------------------------------------
// path: the pixel completing a word passes the level, duty and output registers in turn
// each pixel runs level multiply, duty multiply, pack in turn; the next pixel is taken
//   only after the pack step, which waits while a due word meets a full output register
// the output register lets the next pixel enter while a word waits to go out
// reset: synchronous active-low aresetn clears counters, phase, bit words,
//   output valid and sets the period to 7
module led_pwm_bitplane_packer #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 32,
    parameter int PANEL_WIDTH  = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  lpbp_pkg::pixel_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lpbp_pkg::word_t             m_data,
    input  logic                        cfg_we,
    input  logic [lpbp_pkg::CHAN_W-1:0] cfg_wdata
);

    lpbp_pkg::ctrl_cmd_t  cmd;
    lpbp_pkg::dp_status_t sts;

    lpbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lpbp_datapath #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .PANEL_WIDTH  (PANEL_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTH
    // a due word never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.pack && sts.emit && sts.out_stall))
        else $error("word packed over a held output");

    // an accepted request moves straight to the duty step
    a_accept_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> cmd.calc_duty)
        else $error("duty step did not follow accept");

    // a new word only shows up after a pack
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.pack))
        else $error("output valid without pack");

    // no request is taken while a pixel is in flight
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!cmd.calc_duty && !cmd.pack))
        else $error("ready while busy");
`endif

endmodule

FILE: test/led_pwm_bitplane_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pwm_bitplane_checker
// Watches the pixel and word channels of the bit-plane packer. It tracks the
// raster position, PWM phase and period itself, predicts each packed word and
// compares every word that leaves the block against the oldest prediction.
// ----------------------------------------------------------------------------
module led_pwm_bitplane_checker #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 32,
    parameter int PANEL_WIDTH  = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  lpbp_pkg::pixel_t            s_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  lpbp_pkg::word_t             m_data,
    input  logic                        cfg_we,
    input  logic [lpbp_pkg::CHAN_W-1:0] cfg_wdata,
    output int                          mismatch_count,
    output int                          words_due_count
);
    import lpbp_pkg::*;

    logic [CHAN_W-1:0] period_q;
    logic [CHAN_W-1:0] phase_q;
    int                col_q;
    int                row_q;
    logic [WORD_W-1:0] red_acc;
    logic [WORD_W-1:0] green_acc;
    logic [WORD_W-1:0] blue_acc;

    word_t words_due[$];
    int    bad_words = 0;
    int    owed = 0;

    assign mismatch_count  = bad_words;
    assign words_due_count = owed;

    function automatic logic chan_lit(input logic [CHAN_W-1:0] bright,
                                      input logic [CHAN_W-1:0] chan,
                                      input logic [CHAN_W-1:0] period,
                                      input logic [CHAN_W-1:0] phase);
        int level;
        int duty;
        level = (int'(bright) * int'(chan)) >> 8;
        duty  = (level * (int'(period) + 1)) >> 8;
        return int'(phase) < duty;
    endfunction

    task automatic pack_pixel(input pixel_t px);
        int                bitpos;
        logic [WORD_W-1:0] mask;
        logic              panel_end;
        logic              row_end;
        logic              frame_end;
        word_t             w;
        bitpos    = col_q % PANEL_WIDTH;
        mask      = (bitpos < WORD_W) ? (32'd1 << bitpos) : '0;
        panel_end = (bitpos == PANEL_WIDTH - 1);
        row_end   = (col_q + 1 >= FRAME_WIDTH);
        frame_end = row_end && (row_q + 1 >= FRAME_HEIGHT);

        if (chan_lit(px.pixel_brightness, px.pixel_color[23:16], period_q, phase_q))
            red_acc |= mask;
        if (chan_lit(px.pixel_brightness, px.pixel_color[15:8], period_q, phase_q))
            green_acc |= mask;
        if (chan_lit(px.pixel_brightness, px.pixel_color[7:0], period_q, phase_q))
            blue_acc |= mask;

        // a row end flushes a partial word too
        if (panel_end || row_end) begin
            w.word_address = ADDR_W'(row_q + (col_q / PANEL_WIDTH) * FRAME_HEIGHT);
            w.red_word     = red_acc;
            w.green_word   = green_acc;
            w.blue_word    = blue_acc;
            w.frame_done   = frame_end;
            words_due.push_back(w);
            red_acc   = '0;
            green_acc = '0;
            blue_acc  = '0;
        end

        if (row_end) begin
            col_q = 0;
            if (frame_end) begin
                row_q   = 0;
                phase_q = phase_q + 8'd1;
                // a period lowered below the phase pulls it back here
                if (phase_q >= period_q)
                    phase_q = '0;
            end else begin
                row_q = row_q + 1;
            end
        end else begin
            col_q = col_q + 1;
        end
    endtask

    always @(posedge aclk) begin
        word_t want;
        if (!aresetn) begin
            period_q  = PERIOD_RESET;
            phase_q   = '0;
            col_q     = 0;
            row_q     = 0;
            red_acc   = '0;
            green_acc = '0;
            blue_acc  = '0;
            words_due.delete();
        end else begin
            if (cfg_we)
                period_q = cfg_wdata;
            if (s_valid && s_ready)
                pack_pixel(s_data);
            if (m_valid && m_ready) begin
                if (words_due.size() == 0) begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("%0t: unexpected word addr=%0d r=%h g=%h b=%h done=%b",
                                 $realtime, m_data.word_address, m_data.red_word,
                                 m_data.green_word, m_data.blue_word, m_data.frame_done);
                end else begin
                    want = words_due.pop_front();
                    if (m_data.word_address != want.word_address ||
                        m_data.red_word     != want.red_word     ||
                        m_data.green_word   != want.green_word   ||
                        m_data.blue_word    != want.blue_word    ||
                        m_data.frame_done   != want.frame_done) begin
                        bad_words++;
                        if (bad_words <= 10) begin
                            $display("%0t: word mismatch", $realtime);
                            $display("  expected addr=%0d r=%h g=%h b=%h done=%b",
                                     want.word_address, want.red_word, want.green_word,
                                     want.blue_word, want.frame_done);
                            $display("  actual   addr=%0d r=%h g=%h b=%h done=%b",
                                     m_data.word_address, m_data.red_word,
                                     m_data.green_word, m_data.blue_word,
                                     m_data.frame_done);
                        end
                    end
                end
            end
        end
        owed <= words_due.size();
    end

endmodule

FILE: test/tb_led_pwm_bitplane_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_pwm_bitplane_packer
// Streams pixel requests into the bit-plane packer across several PWM period
// settings and row and panel boundaries, with bursty input and a stalling
// receiver. The checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_led_pwm_bitplane_packer;
    import lpbp_pkg::*;

    localparam int FRAME_WIDTH  = 128;
    localparam int FRAME_HEIGHT = 32;
    localparam int PANEL_WIDTH  = 32;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TICK} rx_mode_e;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    pixel_t            s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    word_t             m_data;
    logic              cfg_we    = 1'b0;
    logic [CHAN_W-1:0] cfg_wdata = '0;

    int mismatch_count;
    int words_due_count;
    int burst_left = 0;

    logic [31:0] corner_px [0:24] = '{
        {8'h00, 24'hFFFFFF}, {8'hFF, 24'hFFFFFF}, {8'hFF, 24'h000000},
        {8'hFF, 24'hFF0000}, {8'hFF, 24'h00FF00}, {8'hFF, 24'h0000FF},
        {8'h01, 24'hFFFFFF}, {8'hFF, 24'h010101}, {8'h80, 24'h808080},
        {8'h7F, 24'h7F7F7F}, {8'hFF, 24'hAAAAAA}, {8'hAA, 24'h555555},
        {8'h55, 24'hAAAAAA}, {8'hFF, 24'h202020}, {8'hFF, 24'h212121},
        {8'h20, 24'hFFFFFF}, {8'h21, 24'hFFFFFF}, {8'hFE, 24'hFEFEFE},
        {8'hFF, 24'h123456}, {8'h00, 24'h000000}, {8'hC0, 24'hC0FFEE},
        {8'hFF, 24'hFF00FF}, {8'h80, 24'hFFFFFF}, {8'hFF, 24'h808080},
        {8'h40, 24'hE0E0E0}
    };

    led_pwm_bitplane_packer #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .PANEL_WIDTH  (PANEL_WIDTH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    led_pwm_bitplane_checker #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .PANEL_WIDTH  (PANEL_WIDTH)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .words_due_count (words_due_count)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver: changing stall modes plus two long hold-offs
    initial begin : receiver
        int       cyc;
        int       mode_left;
        int       hold_left;
        rx_mode_e mode;
        cyc       = 0;
        mode_left = 0;
        hold_left = 0;
        mode      = RX_OPEN;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc == 600 || cyc == 3000)
                hold_left = 300;
            if (mode_left == 0) begin
                mode      = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 400);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= (cyc % 7 != 0);
                endcase
            end
        end
    end

    function automatic logic [7:0] pick_chan();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t px;
        px.pixel_brightness = pick_chan();
        px.pixel_color      = {pick_chan(), pick_chan(), pick_chan()};
        return px;
    endfunction

    task automatic send_pixel(input pixel_t px);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pixel(rand_pixel());
    endtask

    // hold the input until every word has come out and the pipe is empty
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_due_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_period(input logic [CHAN_W-1:0] period);
        cfg_we    <= 1'b1;
        cfg_wdata <= period;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset period, corner pixels first
        for (int i = 0; i < 25; i++)
            send_pixel(pixel_t'(corner_px[i]));
        send_random(275);
        settle();

        // shortest nonzero period mid-frame
        write_period(8'd1);
        send_random(300);
        settle();

        // period zero lights nothing
        write_period(8'd0);
        send_random(300);
        settle();

        write_period(8'd255);
        send_random(250);
        settle();

        write_period(8'd128);
        send_random(250);
        settle();
        repeat (16) @(posedge aclk);

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
